FILE: sv/first_substring_match_finder_macros.svh
// Assertion macros shared by the substring match finder RTL.
`ifndef FIRST_SUBSTRING_MATCH_FINDER_MACROS_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fsmf_pkg.sv
// Shared types and constants of the substring match finder.
`default_nettype none

package fsmf_pkg;

  localparam int unsigned PATTERN_WORD_WIDTH   = 64;
  localparam int unsigned PATTERN_LENGTH_WIDTH = 5;
  localparam int unsigned CFG_INDEX_WIDTH      = 2;
  localparam int unsigned MATCH_INDEX_WIDTH    = 17;
  localparam int unsigned STATUS_WIDTH         = 2;

  localparam logic signed [MATCH_INDEX_WIDTH-1:0] NO_MATCH_INDEX = '1;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_PATTERN_LOW  = 2'd0,
    CFG_PATTERN_HIGH = 2'd1,
    CFG_PATTERN_LEN  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: sv/fsmf_text_if.sv
// Text byte channel: one byte of the text per item.
`default_nettype none

interface fsmf_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/fsmf_result_if.sv
// Result channel: one search result per item.
`default_nettype none

interface fsmf_result_if;
  logic                                          valid;
  logic                                          ready;
  logic                                          found;
  logic signed [fsmf_pkg::MATCH_INDEX_WIDTH-1:0] match_index;
  logic [fsmf_pkg::STATUS_WIDTH-1:0]             status;

  modport source (output valid, output found, output match_index, output status,
                  input ready);
  modport sink (input valid, input found, input match_index, input status,
                output ready);
endinterface

`default_nettype wire

FILE: sv/fsmf_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface fsmf_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [fsmf_pkg::CFG_INDEX_WIDTH-1:0]     index;
  logic [fsmf_pkg::PATTERN_WORD_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/first_substring_match_finder.sv
// A result becomes valid once its last-byte item has passed through the queue and been popped into the result register.
// Throughput: one text byte per cycle while the queue is not full; the result register frees the input side.
// The front compare and the back shift-and update are split by a two-entry queue.
// Input ready drops only while the queue is full behind a stalled result.
// Reset clears pattern registers, match state, queue and result valid at once.
`default_nettype none

module first_substring_match_finder #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned TEXT_INDEX_WIDTH  = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  fsmf_text_if.sink      text_i,
  fsmf_cfg_if.sink       cfg_i,
  fsmf_result_if.source  result_o
);
  import fsmf_pkg::*;

  localparam int unsigned LenWidth   = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned EntryWidth = MAX_PATTERN_BYTES + LenWidth + 1;

  queue_status_t          queue_status;
  logic                   push;
  logic                   pop;
  logic [EntryWidth-1:0]  push_entry;
  logic [EntryWidth-1:0]  pop_entry;

  fsmf_front #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .LEN_WIDTH         (LenWidth),
    .ENTRY_WIDTH       (EntryWidth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .text_i         (text_i),
    .cfg_i          (cfg_i),
    .queue_status_i (queue_status),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  fsmf_queue #(
    .WIDTH (EntryWidth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_entry),
    .pop_i    (pop),
    .data_o   (pop_entry),
    .status_o (queue_status)
  );

  fsmf_back #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .TEXT_INDEX_WIDTH  (TEXT_INDEX_WIDTH),
    .LEN_WIDTH         (LenWidth),
    .ENTRY_WIDTH       (EntryWidth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (pop_entry),
    .queue_status_i (queue_status),
    .pop_o          (pop),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

FILE: sv/fsmf_front.sv
// Front end: configuration registers, byte accept and per-position compare.
`default_nettype none

module fsmf_front #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned LEN_WIDTH         = 5,
  parameter int unsigned ENTRY_WIDTH       = 22
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  fsmf_text_if.sink                   text_i,
  fsmf_cfg_if.sink                    cfg_i,
  input  fsmf_pkg::queue_status_t     queue_status_i,
  output logic                        push_o,
  output logic [ENTRY_WIDTH-1:0]      entry_o
);
  import fsmf_pkg::*;

  localparam logic [PATTERN_LENGTH_WIDTH-1:0] MaxLen = PATTERN_LENGTH_WIDTH'(MAX_PATTERN_BYTES);

  logic [PATTERN_WORD_WIDTH-1:0]   pat_low_q;
  logic [PATTERN_WORD_WIDTH-1:0]   pat_high_q;
  logic [PATTERN_LENGTH_WIDTH-1:0] pat_len_q;
  logic [2*PATTERN_WORD_WIDTH-1:0] pat_all;
  logic [PATTERN_LENGTH_WIDTH-1:0] len_clamped;
  logic [LEN_WIDTH-1:0]            used_len;
  logic [MAX_PATTERN_BYTES-1:0]    eq;

  assign cfg_i.ready  = 1'b1;
  assign text_i.ready = !queue_status_i.full;
  assign push_o       = text_i.valid && !queue_status_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_PATTERN_LOW:  pat_low_q  <= cfg_i.data;
        CFG_PATTERN_HIGH: pat_high_q <= cfg_i.data;
        CFG_PATTERN_LEN:  pat_len_q  <= cfg_i.data[PATTERN_LENGTH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all     = {pat_high_q, pat_low_q};
  assign len_clamped = (pat_len_q > MaxLen) ? MaxLen : pat_len_q;
  assign used_len    = LEN_WIDTH'(len_clamped);

  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      eq[k] = (LEN_WIDTH'(k) < used_len) && (pat_all[8*k +: 8] == text_i.text_byte);
    end
  end

  assign entry_o = {text_i.last_byte, used_len, eq};

endmodule

`default_nettype wire

FILE: sv/fsmf_queue.sv
// Two-entry queue between the compare front end and the match back end.
`default_nettype none
`include "first_substring_match_finder_macros.svh"

module fsmf_queue #(
  parameter int unsigned WIDTH = 22
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  logic                     push_i,
  input  logic [WIDTH-1:0]         data_i,
  input  logic                     pop_i,
  output logic [WIDTH-1:0]         data_o,
  output fsmf_pkg::queue_status_t  status_o
);
  import fsmf_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);

  `FSMF_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q != 2'd3, "queue count out of range")
  `FSMF_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop_i, cnt_q != 2'd0, "pop from empty queue")
  `FSMF_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push_i, cnt_q != 2'd2, "push into full queue")

endmodule

`default_nettype wire

FILE: sv/fsmf_back.sv
// Back end: shift-and match vector, position tracking and result register.
`default_nettype none
`include "first_substring_match_finder_macros.svh"

module fsmf_back #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned TEXT_INDEX_WIDTH  = 16,
  parameter int unsigned LEN_WIDTH         = 5,
  parameter int unsigned ENTRY_WIDTH       = 22
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  logic [ENTRY_WIDTH-1:0]   entry_i,
  input  fsmf_pkg::queue_status_t  queue_status_i,
  output logic                     pop_o,
  fsmf_result_if.source            result_o
);
  import fsmf_pkg::*;

  localparam logic [TEXT_INDEX_WIDTH-1:0] PosMax = '1;

  logic [MAX_PATTERN_BYTES-1:0] pmv_q, pmv_n, pmv_d, hit_vec;
  logic [TEXT_INDEX_WIDTH-1:0]  pos_q, pos_n, pos_d;
  logic [TEXT_INDEX_WIDTH-1:0]  start_q, start_n, start_d;
  logic                         full_q, full_n, full_d;
  logic                         seen_q, seen_n, seen_d;
  logic                         ovf_q, ovf_n, ovf_d;
  logic                         res_valid_q, res_valid_d;
  logic                         found_q;
  logic signed [MATCH_INDEX_WIDTH-1:0] index_q;
  status_e                      status_q, status_n;
  logic [MAX_PATTERN_BYTES-1:0] eq;
  logic [LEN_WIDTH-1:0]         len;
  logic                         last;
  logic                         hit;
  logic [31:0]                  start_ext;
  logic signed [MATCH_INDEX_WIDTH-1:0] index_n;

  assign eq   = entry_i[MAX_PATTERN_BYTES-1:0];
  assign len  = entry_i[MAX_PATTERN_BYTES +: LEN_WIDTH];
  assign last = entry_i[MAX_PATTERN_BYTES + LEN_WIDTH];

  assign pop_o = !queue_status_i.empty && (!res_valid_q || result_o.ready);

  always_comb begin
    pmv_n   = pmv_q;
    pos_n   = pos_q;
    start_n = start_q;
    full_n  = full_q;
    seen_n  = seen_q;
    ovf_n   = ovf_q;
    hit_vec = ((pmv_q << 1) | MAX_PATTERN_BYTES'(1)) & eq;
    hit     = 1'b0;
    if (pop_o) begin
      if (full_q) begin
        ovf_n = 1'b1;
      end else begin
        pmv_n = hit_vec;
        hit   = (len != '0) && ((hit_vec >> (len - LEN_WIDTH'(1))) & MAX_PATTERN_BYTES'(1))
                != '0;
        if (hit && !seen_q) begin
          seen_n  = 1'b1;
          start_n = pos_q - TEXT_INDEX_WIDTH'(len - LEN_WIDTH'(1));
        end
        if (pos_q == PosMax) begin
          full_n = 1'b1;
        end else begin
          pos_n = pos_q + TEXT_INDEX_WIDTH'(1);
        end
      end
    end

    start_ext = 32'(start_n);
    index_n   = seen_n ? signed'(start_ext[MATCH_INDEX_WIDTH-1:0]) : NO_MATCH_INDEX;
    if (len == '0) begin
      status_n = STATUS_EMPTY;
    end else if (seen_n) begin
      status_n = STATUS_OK;
    end else if (ovf_n) begin
      status_n = STATUS_RANGE;
    end else begin
      status_n = STATUS_OK;
    end

    if (pop_o && last) begin
      pmv_d   = '0;
      pos_d   = '0;
      start_d = '0;
      full_d  = 1'b0;
      seen_d  = 1'b0;
      ovf_d   = 1'b0;
    end else begin
      pmv_d   = pmv_n;
      pos_d   = pos_n;
      start_d = start_n;
      full_d  = full_n;
      seen_d  = seen_n;
      ovf_d   = ovf_n;
    end

    if (pop_o && last) begin
      res_valid_d = 1'b1;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmv_q       <= '0;
      pos_q       <= '0;
      start_q     <= '0;
      full_q      <= 1'b0;
      seen_q      <= 1'b0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      pmv_q       <= pmv_d;
      pos_q       <= pos_d;
      start_q     <= start_d;
      full_q      <= full_d;
      seen_q      <= seen_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && last) begin
      found_q  <= seen_n;
      index_q  <= index_n;
      status_q <= status_n;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.found       = found_q;
  assign result_o.match_index = index_q;
  assign result_o.status      = status_q;

  `FSMF_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, pop_o && last,
                    pos_q == '0 && !seen_q && !ovf_q && !full_q, "text state not cleared")
  `FSMF_ASSERT_NOW(a_result_source, clk_i, rst_ni, res_valid_q && !$past(res_valid_q),
                   $past(pop_o && last), "result without a last item")
  `FSMF_ASSERT_NOW(a_overflow_needs_full, clk_i, rst_ni, ovf_q, full_q,
                   "overflow without a full index range")

endmodule

`default_nettype wire

FILE: verif/first_substring_match_finder_tb.sv
`timescale 1ns / 1ps
// Testbench for the substring match finder: predicts every search result and checks the output.
module first_substring_match_finder_tb;
  import fsmf_pkg::*;

  localparam int unsigned MAX_BYTES = 16;
  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned PHASE_ITEMS = 300;

  typedef logic [7:0] text_q_t[$];

  typedef struct {
    logic                                found;
    logic signed [MATCH_INDEX_WIDTH-1:0] match_index;
    status_e                             status;
  } search_result_t;

  logic clk_i;
  logic rst_ni;

  fsmf_text_if   text_ch();
  fsmf_cfg_if    cfg_ch();
  fsmf_result_if result_ch();

  first_substring_match_finder #(
    .MAX_PATTERN_BYTES(MAX_BYTES),
    .TEXT_INDEX_WIDTH(INDEX_BITS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .text_i(text_ch),
    .cfg_i(cfg_ch),
    .result_o(result_ch)
  );

  logic [PATTERN_WORD_WIDTH-1:0]   pattern_low;
  logic [PATTERN_WORD_WIDTH-1:0]   pattern_high;
  logic [PATTERN_LENGTH_WIDTH-1:0] pattern_len;
  logic [MAX_BYTES-1:0]            partial_vec;
  logic [INDEX_BITS-1:0]           text_pos;
  logic [INDEX_BITS-1:0]           first_start;
  logic                            match_seen;
  logic                            pos_overflow;
  logic                            range_full;

  search_result_t pending_results[$];
  search_result_t want;
  int             mismatch_count;
  int             idle_cycles;
  int             hold_cycles;
  int             random_items;
  bit             quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned active_length();
    return (pattern_len > MAX_BYTES) ? MAX_BYTES : pattern_len;
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned k);
    logic [2*PATTERN_WORD_WIDTH-1:0] both;
    both = {pattern_high, pattern_low};
    return both[8*k +: 8];
  endfunction

  function automatic void clear_text_state();
    partial_vec  = '0;
    text_pos     = '0;
    first_start  = '0;
    match_seen   = 1'b0;
    pos_overflow = 1'b0;
    range_full   = 1'b0;
  endfunction

  function automatic void scan_text_byte(logic [7:0] b, logic last);
    int unsigned          len;
    logic [MAX_BYTES-1:0] eq;
    search_result_t       r;
    len = active_length();
    eq = '0;
    if (range_full) begin
      pos_overflow = 1'b1;
    end else begin
      for (int k = 0; k < len; k++) begin
        if (pattern_byte(k) == b) eq[k] = 1'b1;
      end
      partial_vec = {partial_vec[MAX_BYTES-2:0], 1'b1} & eq;
      if (len != 0 && !match_seen && partial_vec[len-1]) begin
        match_seen = 1'b1;
        first_start = text_pos - INDEX_BITS'(len - 1);
      end
      if (text_pos == {INDEX_BITS{1'b1}}) range_full = 1'b1;
      else text_pos = text_pos + 1'b1;
    end
    if (!last) return;
    if (len == 0) begin
      r.found = 1'b0;
      r.match_index = NO_MATCH_INDEX;
      r.status = STATUS_EMPTY;
    end else if (match_seen) begin
      r.found = 1'b1;
      r.match_index = {1'b0, first_start};
      r.status = STATUS_OK;
    end else begin
      r.found = 1'b0;
      r.match_index = NO_MATCH_INDEX;
      r.status = pos_overflow ? STATUS_RANGE : STATUS_OK;
    end
    pending_results.push_back(r);
    clear_text_state();
  endfunction

  task automatic send_text_byte(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      text_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    text_ch.valid = 1'b1;
    text_ch.text_byte = b;
    text_ch.last_byte = last;
    do @(posedge clk_i); while (!text_ch.ready);
    scan_text_byte(b, last);
    @(negedge clk_i);
    text_ch.valid = 1'b0;
  endtask

  task automatic send_text(input text_q_t bytes);
    foreach (bytes[i]) send_text_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [PATTERN_WORD_WIDTH-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_PATTERN_LOW: pattern_low = value;
      CFG_PATTERN_HIGH: pattern_high = value;
      CFG_PATTERN_LEN: pattern_len = value[PATTERN_LENGTH_WIDTH-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic configure(input logic [PATTERN_WORD_WIDTH-1:0] low,
                           input logic [PATTERN_WORD_WIDTH-1:0] high,
                           input logic [PATTERN_LENGTH_WIDTH-1:0] len);
    wait_idle();
    write_register(CFG_PATTERN_LOW, low);
    write_register(CFG_PATTERN_HIGH, high);
    write_register(CFG_PATTERN_LEN, {{(PATTERN_WORD_WIDTH-PATTERN_LENGTH_WIDTH){1'b0}}, len});
  endtask

  task automatic send_random_text(input int max_len, output int count);
    text_q_t     t;
    int unsigned n;
    int unsigned len;
    int unsigned at;
    bit          noise;
    n = $urandom_range(1, max_len);
    len = active_length();
    noise = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if (noise || len == 0 || $urandom_range(0, 3) == 0) t.push_back(8'($urandom));
      else t.push_back(pattern_byte($urandom_range(0, len - 1)));
    end
    if (!noise && len != 0 && n >= len && $urandom_range(0, 1) == 1) begin
      at = $urandom_range(0, n - len);
      for (int k = 0; k < len; k++) t[at + k] = pattern_byte(k);
      // break the planted copy now and then for a near miss
      if ($urandom_range(0, 3) == 0) t[at + $urandom_range(0, len - 1)] ^= 8'($urandom_range(1, 255));
    end
    send_text(t);
    count = n;
  endtask

  task automatic test_empty_pattern();
    text_q_t t;
    t = '{8'h00};
    send_text(t);
    t = '{8'hFF, 8'h00};
    send_text(t);
  endtask

  task automatic test_directed_matches();
    text_q_t t;
    configure(64'hFF, 64'h0, 5'd1);
    t = '{8'h00, 8'hFF};
    send_text(t);
    configure(64'h01_02_01, 64'h0, 5'd3);
    t = '{8'h01, 8'h01, 8'h02, 8'h01, 8'h02, 8'h01};
    send_text(t);
    t = '{8'h02};
    send_text(t);
    // overlong length behaves as the full sixteen bytes
    configure('1, '1, 5'd31);
    for (int i = 0; i < MAX_BYTES; i++) send_text_byte(8'hFF, i == MAX_BYTES - 1);
  endtask

  task automatic test_backpressure();
    logic [7:0] b;
    configure({56'h0, 8'($urandom)}, 64'h0, 5'd1);
    hold_cycles = 200;
    for (int i = 0; i < 40; i++) begin
      b = ($urandom_range(0, 1) == 1) ? pattern_low[7:0] : 8'($urandom);
      send_text_byte(b, 1'b1);
    end
    wait_idle();
  endtask

  task automatic test_index_overflow();
    logic [7:0] b;
    configure(64'hA5_5A, 64'h0, 5'd2);
    // no match inside the index range; the pattern only shows up past it
    for (int i = 0; i < (1 << INDEX_BITS); i++) begin
      b = 8'($urandom);
      if (b == 8'h5A) b = 8'h5B;
      send_text_byte(b, 1'b0);
    end
    send_text_byte(8'h5A, 1'b0);
    send_text_byte(8'hA5, 1'b1);
    // match ending at the largest index, then more matches past the range
    for (int i = 0; i < (1 << INDEX_BITS) - 2; i++) begin
      b = 8'($urandom);
      if (b == 8'h5A) b = 8'h5B;
      send_text_byte(b, 1'b0);
    end
    for (int i = 0; i < 6; i++) send_text_byte(i[0] ? 8'hA5 : 8'h5A, i == 5);
  endtask

  task automatic test_random_texts();
    logic [2*PATTERN_WORD_WIDTH-1:0] pat;
    logic [PATTERN_LENGTH_WIDTH-1:0] len;
    logic [7:0]                      a;
    logic [7:0]                      c;
    int                              mode;
    int                              phase_items;
    int                              n;
    for (int phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      case (phase)
        0: len = 5'd16;
        1: len = 5'd0;
        2: len = 5'd31;
        default: len = 5'($urandom_range(1, 15));
      endcase
      mode = $urandom_range(0, 5);
      a = 8'($urandom);
      c = 8'($urandom);
      for (int k = 0; k < 2 * PATTERN_WORD_WIDTH / 8; k++) begin
        case (mode)
          0, 1: pat[8*k +: 8] = ($urandom_range(0, 1) == 1) ? a : c;
          2: pat[8*k +: 8] = 8'h00;
          3: pat[8*k +: 8] = 8'hFF;
          default: pat[8*k +: 8] = 8'($urandom);
        endcase
      end
      if (random_items + PHASE_ITEMS >= RANDOM_ITEMS) quiet = 1'b1;
      configure(pat[PATTERN_WORD_WIDTH-1:0], pat[2*PATTERN_WORD_WIDTH-1:PATTERN_WORD_WIDTH], len);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        send_random_text(40, n);
        phase_items += n;
      end
      random_items += phase_items;
    end
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        result_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        result_ch.ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      result_ch.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result found=%0b index=%0d status=%0d", $time,
                 result_ch.found, result_ch.match_index, result_ch.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if ({result_ch.found, result_ch.match_index, result_ch.status} !==
            {want.found, want.match_index, want.status}) begin
          $display("%0t: expected found=%0b index=%0d status=%0d, got found=%0b index=%0d status=%0d",
                   $time, want.found, want.match_index, want.status,
                   result_ch.found, result_ch.match_index, result_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (text_ch.valid && text_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (result_ch.valid && result_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    text_ch.valid = 1'b0;
    text_ch.text_byte = '0;
    text_ch.last_byte = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_PATTERN_LOW;
    cfg_ch.data = '0;
    quiet = 1'b0;
    hold_cycles = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    random_items = 0;
    pattern_low = '0;
    pattern_high = '0;
    pattern_len = '0;
    clear_text_state();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_pattern();
    test_directed_matches();
    test_backpressure();
    test_index_overflow();
    test_random_texts();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/fsmf_pkg.sv
sv/fsmf_text_if.sv
sv/fsmf_result_if.sv
sv/fsmf_cfg_if.sv
sv/fsmf_front.sv
sv/fsmf_queue.sv
sv/fsmf_back.sv
sv/first_substring_match_finder.sv
verif/first_substring_match_finder_tb.sv
